FILE: hw/rtl/byte_ring_fifo_peek_skip_assert.svh
// Assertion macros used by the FIFO checker.
`ifndef BYTE_RING_FIFO_PEEK_SKIP_ASSERT_SVH
`define BYTE_RING_FIFO_PEEK_SKIP_ASSERT_SVH

// Condition in one cycle implies consequence in the next.
`define BRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Condition implies consequence in the same cycle.
`define BRF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/brf_pkg.sv
package brf_pkg;

	localparam int DEPTH = 256;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = 9;
	localparam int OP_W  = 3;
	localparam int CAP_W = 9;

	typedef enum logic [OP_W-1:0] {
		OP_PUT   = 3'd0,
		OP_GET   = 3'd1,
		OP_PEEK  = 3'd2,
		OP_SKIP  = 3'd3,
		OP_FLUSH = 3'd4
	} op_t;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [7:0]       data_in;
		logic [CNT_W-1:0] amount;
	} cmd_t;

	typedef struct packed {
		logic             ok;
		logic [7:0]       data_out;
		logic [CNT_W-1:0] dropped;
		logic [CNT_W-1:0] fill_level;
		logic [CNT_W-1:0] free_space;
		logic             empty_res;
		logic             full_res;
	} res_t;

	// Store access issued by the control logic for one beat.
	typedef struct packed {
		logic             we;
		logic [PTR_W-1:0] waddr;
		logic [7:0]       wdata;
		logic             re;
		logic [PTR_W-1:0] raddr;
	} mem_req_t;

endpackage

FILE: hw/rtl/brf_ram.sv
module brf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/brf_ctrl.sv
module brf_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  brf_pkg::cmd_t               cmd,
	input  logic [brf_pkg::CAP_W-1:0]   capacity,
	input  logic [7:0]                  rdata,
	output brf_pkg::mem_req_t           mem_req,
	output logic                        done,
	output brf_pkg::res_t               res
);

	import brf_pkg::*;

	localparam int SUM_W = CNT_W + 1;
	localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(DEPTH);

	logic [PTR_W-1:0] rd_pos_q, wr_pos_q, rd_pos_d, wr_pos_d;
	logic [CNT_W-1:0] fill_q, fill_d;
	logic [CAP_W-1:0] cap_eff;
	logic             ok_d, rd_d;
	logic [CNT_W-1:0] drop_d, free_d;

	logic             done_s1, rd_s1;
	logic             ok_s1, empty_s1, full_s1;
	logic [CNT_W-1:0] drop_s1, fill_s1, free_s1;

	// Add, then take the capacity off once; anything still out of range restarts at zero.
	function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] pos,
			input logic [CNT_W-1:0] inc, input logic [CAP_W-1:0] cap);
		logic [SUM_W-1:0] s;
		s = SUM_W'(pos) + SUM_W'(inc);
		if (s >= SUM_W'(cap)) begin
			s = s - SUM_W'(cap);
		end
		if (s >= SUM_W'(cap)) begin
			s = '0;
		end
		return s[PTR_W-1:0];
	endfunction

	always_comb begin
		if (capacity == '0) begin
			cap_eff = CAP_W'(1);
		end else if (capacity > CAP_MAX) begin
			cap_eff = CAP_MAX;
		end else begin
			cap_eff = capacity;
		end

		rd_pos_d      = rd_pos_q;
		wr_pos_d      = wr_pos_q;
		fill_d        = fill_q;
		ok_d          = 1'b0;
		rd_d          = 1'b0;
		drop_d        = '0;
		mem_req.we    = 1'b0;
		mem_req.waddr = wr_pos_q;
		mem_req.wdata = cmd.data_in;
		mem_req.re    = 1'b0;
		mem_req.raddr = rd_pos_q;

		if (accept) begin
			case (cmd.operation)
				OP_PUT: begin
					if (CAP_W'(fill_q) < cap_eff) begin
						mem_req.we = 1'b1;
						wr_pos_d   = wrap_add(wr_pos_q, CNT_W'(1), cap_eff);
						fill_d     = fill_q + CNT_W'(1);
						ok_d       = 1'b1;
					end
				end
				OP_GET: begin
					if (fill_q != '0) begin
						mem_req.re = 1'b1;
						rd_d       = 1'b1;
						rd_pos_d   = wrap_add(rd_pos_q, CNT_W'(1), cap_eff);
						fill_d     = fill_q - CNT_W'(1);
						ok_d       = 1'b1;
					end
				end
				OP_PEEK: begin
					if (cmd.amount < fill_q) begin
						mem_req.re    = 1'b1;
						mem_req.raddr = wrap_add(rd_pos_q, cmd.amount, cap_eff);
						rd_d          = 1'b1;
						ok_d          = 1'b1;
					end
				end
				OP_SKIP: begin
					drop_d   = (cmd.amount > fill_q) ? fill_q : cmd.amount;
					rd_pos_d = wrap_add(rd_pos_q, drop_d, cap_eff);
					fill_d   = fill_q - drop_d;
					ok_d     = 1'b1;
				end
				OP_FLUSH: begin
					rd_pos_d = '0;
					wr_pos_d = '0;
					fill_d   = '0;
					ok_d     = 1'b1;
				end
				default: begin
				end
			endcase
		end

		free_d = (CAP_W'(fill_d) < cap_eff) ? CNT_W'(cap_eff - CAP_W'(fill_d)) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pos_q <= '0;
			wr_pos_q <= '0;
			fill_q   <= '0;
			done_s1  <= 1'b0;
			rd_s1    <= 1'b0;
		end else begin
			rd_pos_q <= rd_pos_d;
			wr_pos_q <= wr_pos_d;
			fill_q   <= fill_d;
			done_s1  <= accept;
			rd_s1    <= rd_d;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1    <= ok_d;
		drop_s1  <= drop_d;
		fill_s1  <= fill_d;
		free_s1  <= free_d;
		empty_s1 <= (fill_d == '0);
		full_s1  <= (CAP_W'(fill_d) >= cap_eff);
	end

	// Read data lands from the store in the result cycle; zero it for non-reads.
	always_comb begin
		done           = done_s1;
		res.ok         = ok_s1;
		res.data_out   = rd_s1 ? rdata : 8'd0;
		res.dropped    = drop_s1;
		res.fill_level = fill_s1;
		res.free_space = free_s1;
		res.empty_res  = empty_s1;
		res.full_res   = full_s1;
	end

endmodule

FILE: hw/rtl/byte_ring_fifo_peek_skip.sv
// Each accepted command shows its result on res, strobed by done, in the following cycle.
// Throughput: one command per cycle while busy is low; the store is one RAM with one write and one
// registered read port, and the read data forms the result register for get and peek.
// The receiver cannot stall: each result is presented for exactly one cycle.
// Reset: pointers and fill count clear, capacity returns to 256, store contents are kept;
// busy stays high through reset and the first cycle after it.
module byte_ring_fifo_peek_skip (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  brf_pkg::cmd_t              cmd,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [brf_pkg::CAP_W-1:0]  cfg_data,
	output logic                       done,
	output brf_pkg::res_t              res
);

	import brf_pkg::*;

	logic             busy_q;
	logic [CAP_W-1:0] capacity_q;
	logic             accept;
	mem_req_t         mem_req;
	logic [7:0]       rdata;

	assign busy      = busy_q;
	assign cfg_ready = !busy_q;
	assign accept    = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			capacity_q <= CAP_W'(256);
		end else begin
			busy_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end
		end
	end

	brf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (cmd),
		.capacity (capacity_q),
		.rdata    (rdata),
		.mem_req  (mem_req),
		.done     (done),
		.res      (res)
	);

	brf_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

endmodule

FILE: hw/rtl/brf_checker.sv
`include "byte_ring_fifo_peek_skip_assert.svh"

module brf_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  logic          done,
	input  brf_pkg::res_t res
);

	// Every accepted beat answers in the next cycle, and only then.
	`BRF_ASSERT_NEXT(a_result_follows, clk, arst_n, start && !busy, done, "result missing")
	`BRF_ASSERT_NEXT(a_no_spurious, clk, arst_n, !(start && !busy), !done, "spurious result")
	`BRF_ASSERT_NOW(a_empty_flag, clk, arst_n, done, res.empty_res == (res.fill_level == '0), "empty flag mismatch")
	`BRF_ASSERT_NOW(a_fail_no_data, clk, arst_n, done && !res.ok, res.data_out == 8'd0, "data on failed beat")
	`BRF_ASSERT_NOW(a_full_no_space, clk, arst_n, done && res.full_res, res.free_space == '0, "free space while full")

endmodule

bind byte_ring_fifo_peek_skip brf_checker u_brf_checker (.*);
